// ===== rtl/imu_quaternion_mount_and_yaw_zero_defines.svh =====
// ----------------------------------------------------------------------------
// IMU mount and yaw-zero assertion macros
// Concurrent check macros used by the top level; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IMU_QUATERNION_MOUNT_AND_YAW_ZERO_DEFINES_SVH
`define IMU_QUATERNION_MOUNT_AND_YAW_ZERO_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define IMUYZ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imuyz: same-cycle check failed");
// next-cycle implication
`define IMUYZ_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imuyz: next-cycle check failed");
`else
`define IMUYZ_ASSERT_IMP(name, clk, rst, ante, cons)
`define IMUYZ_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/imuyz_pkg.sv =====
// ----------------------------------------------------------------------------
// imuyz_pkg
// Types, constants and tables shared by the IMU mount and yaw-zero block.
// ----------------------------------------------------------------------------
package imuyz_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int CORDIC_STEPS    = 16;

  localparam int QW   = 24;  // working quaternion component
  localparam int CSW  = 18;  // cos / sin coefficient
  localparam int PW   = 48;  // product
  localparam int AW   = 50;  // accumulator
  localparam int TW   = 44;  // yaw vector terms
  localparam int CXW  = 34;  // CORDIC x / y
  localparam int CZW  = 36;  // CORDIC angle
  localparam int ANGW = 17;  // angle operand before scaling
  localparam int PADDR_W = 4;

  localparam int RND_CS     = 30 - QUAT_FRAC_BITS;
  localparam int HALF_SHIFT = 29 - ANGLE_FRAC_BITS;
  localparam int RND_ANG    = 30 - ANGLE_FRAC_BITS;

  localparam logic signed [CZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CXW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam longint SQRT_HALF_Q30 = 64'sd759250125;
  localparam logic signed [CSW-1:0] R45_C =
    CSW'((SQRT_HALF_Q30 + (64'sd1 <<< (RND_CS - 1))) >>> RND_CS);
  localparam logic signed [TW-1:0] T_LIM = TW'(64'sd1 <<< 30);
  localparam logic signed [QW-1:0] OUT_LIM = QW'(64'sd1 <<< QUAT_FRAC_BITS);

  // register map
  localparam logic [1:0] REG_ROLL  = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_YAW   = 2'd2;

  // quaternion component indexes
  localparam logic [1:0] IDX_W = 2'd0;
  localparam logic [1:0] IDX_X = 2'd1;
  localparam logic [1:0] IDX_Y = 2'd2;
  localparam logic [1:0] IDX_Z = 2'd3;

  typedef enum logic [2:0] {
    ROT_R45    = 3'd0,
    ROT_MYAW   = 3'd1,
    ROT_MPITCH = 3'd2,
    ROT_MROLL  = 3'd3,
    ROT_SYAW   = 3'd4
  } rot_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT_LOAD, ST_WRAP, ST_FOLD, ST_CORDIC, ST_CS_DONE, ST_QMUL,
    ST_YAW_MAC, ST_YAW_NORM, ST_YAW_PRE, ST_YAW_CORDIC, ST_YAW_LATCH, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       cs_load;
    logic       cs_wrap;
    logic       cs_fold;
    logic       cor_step;
    logic       cor_vec;
    logic       cs_done;
    logic       mac_en;
    logic       mac_clr;
    logic       mac_yaw;
    logic [1:0] mac_comp;
    logic       mac_term;
    logic       q_wr;
    logic [1:0] q_wr_comp;
    logic       q_commit;
    logic       t0_wr;
    logic       t1_wr;
    logic       t_shift;
    logic       yaw_pre;
    logic       yaw_latch;
    logic       out_load;
    rot_t       rot;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic t_big;
    logic t_zero;
  } status_t;

  typedef struct packed {
    logic [1:0] idx;
    logic       neg;
  } term_t;

  // second term of a product with a single-axis rotation (c + s*axis)
  function automatic term_t partner(input rot_t rot, input logic [1:0] k);
    term_t t;
    t.idx = IDX_W;
    t.neg = 1'b0;
    unique case (rot)
      ROT_SYAW: begin  // left multiply about z
        case (k)
          IDX_W:   begin t.idx = IDX_Z; t.neg = 1'b1; end
          IDX_X:   begin t.idx = IDX_Y; t.neg = 1'b1; end
          IDX_Y:   begin t.idx = IDX_X; t.neg = 1'b0; end
          default: begin t.idx = IDX_W; t.neg = 1'b0; end
        endcase
      end
      ROT_MPITCH: begin
        case (k)
          IDX_W:   begin t.idx = IDX_Y; t.neg = 1'b1; end
          IDX_X:   begin t.idx = IDX_Z; t.neg = 1'b1; end
          IDX_Y:   begin t.idx = IDX_W; t.neg = 1'b0; end
          default: begin t.idx = IDX_X; t.neg = 1'b0; end
        endcase
      end
      ROT_MROLL: begin
        case (k)
          IDX_W:   begin t.idx = IDX_X; t.neg = 1'b1; end
          IDX_X:   begin t.idx = IDX_W; t.neg = 1'b0; end
          IDX_Y:   begin t.idx = IDX_Z; t.neg = 1'b0; end
          default: begin t.idx = IDX_Y; t.neg = 1'b1; end
        endcase
      end
      default: begin  // right multiply about z
        case (k)
          IDX_W:   begin t.idx = IDX_Z; t.neg = 1'b1; end
          IDX_X:   begin t.idx = IDX_Y; t.neg = 1'b0; end
          IDX_Y:   begin t.idx = IDX_X; t.neg = 1'b1; end
          default: begin t.idx = IDX_W; t.neg = 1'b0; end
        endcase
      end
    endcase
    return t;
  endfunction

  // elementary CORDIC angle atan(2^-i), Q.30
  function automatic logic signed [CZW-1:0] atan_step(input logic [4:0] i);
    logic signed [CZW-1:0] r;
    case (i)
      5'd0:    r = 36'sd843314856;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043836;
      5'd3:    r = 36'sd133525158;
      5'd4:    r = 36'sd67021686;
      5'd5:    r = 36'sd33543515;
      5'd6:    r = 36'sd16775850;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194282;
      5'd9:    r = 36'sd2097149;
      5'd31:   r = '0;
      default: r = 36'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/imu_quaternion_mount_and_yaw_zero.sv =====
// ----------------------------------------------------------------------------
// imu_quaternion_mount_and_yaw_zero
// IMU quaternion mounting correction with removal of the first sample's yaw.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one Q1.14 quaternion per transaction.
// Output channel (out_valid/out_ready): one corrected, saturated quaternion
// per input transaction, in order.
// APB port: mount_roll at 0x0, mount_pitch at 0x4, mount_yaw at 0x8 (Q3.12
// radians, 15 bits); write only while the block is idle.
// Each item passes through four sin/cos evaluations on one iterative CORDIC and
// five quaternion products on one shared multiplier (the fixed 45 degree term
// needs no sin/cos), then the output step. The first item after reset also
// captures the start yaw: the yaw-vector multiply-accumulate, normalization
// (repeated while the vector must be halved) and a 16-step vectoring pass with
// setup and latch; the vectoring pass is skipped when the yaw vector is zero.
// in_ready is high only between items, so a new item is taken only after the
// last one has left the sequencer.
// Reset: mounting angles clear to zero and the next item captures the yaw.
// Stall: a result waits in the output register while a new item is taken;
// the following result is held until the register frees.
// ----------------------------------------------------------------------------
`include "imu_quaternion_mount_and_yaw_zero_defines.svh"

module imu_quaternion_mount_and_yaw_zero (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_w,
  input  logic signed [15:0]                 in_x,
  input  logic signed [15:0]                 in_y,
  input  logic signed [15:0]                 in_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_w,
  output logic signed [15:0]                 out_x,
  output logic signed [15:0]                 out_y,
  output logic signed [15:0]                 out_z,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [imuyz_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic signed [14:0] mount_roll, mount_pitch, mount_yaw;
  logic               wr_en;
  imuyz_pkg::cmd_t    cmd;
  imuyz_pkg::status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_roll  <= '0;
      mount_pitch <= '0;
      mount_yaw   <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        imuyz_pkg::REG_ROLL:  mount_roll  <= pwdata[14:0];
        imuyz_pkg::REG_PITCH: mount_pitch <= pwdata[14:0];
        imuyz_pkg::REG_YAW:   mount_yaw   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      imuyz_pkg::REG_ROLL:  prdata = 32'(mount_roll);
      imuyz_pkg::REG_PITCH: prdata = 32'(mount_pitch);
      imuyz_pkg::REG_YAW:   prdata = 32'(mount_yaw);
      default:              prdata = '0;
    endcase
  end

  imuyz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  imuyz_dpath u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .in_w        (in_w),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .mount_roll  (mount_roll),
    .mount_pitch (mount_pitch),
    .mount_yaw   (mount_yaw),
    .out_w       (out_w),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z)
  );

  // busy after a transaction is taken
  `IMUYZ_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // a new result appears only as the sequencer returns to idle
  `IMUYZ_ASSERT_IMP(a_result_then_idle, clk, rst, $rose(out_valid), in_ready)
  // delivered w and z components stay inside the saturation range
  `IMUYZ_ASSERT_IMP(a_out_sat, clk, rst, out_valid, out_w <= 16'sd16384 && out_w >= -16'sd16384 && out_z <= 16'sd16384 && out_z >= -16'sd16384)

endmodule

// ===== rtl/imuyz_ctrl.sv =====
// ----------------------------------------------------------------------------
// imuyz_ctrl
// Sequencer: steps the datapath through the rotations, the one-time yaw
// capture and the output register handoff.
// ----------------------------------------------------------------------------
module imuyz_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  imuyz_pkg::status_t  status,
  output imuyz_pkg::cmd_t     cmd
);

  imuyz_pkg::state_t state, state_next;
  imuyz_pkg::rot_t   rot, rot_next;
  logic [4:0]        cnt, cnt_next;
  logic              awaiting_first, awaiting_first_next;
  logic              out_valid_next;
  logic [4:0]        cnt_m1;
  logic              last_step;
  logic              out_free;

  assign last_step = (cnt == 5'(imuyz_pkg::CORDIC_STEPS - 1));
  assign out_free  = !out_valid || out_ready;
  assign cnt_m1    = cnt - 5'd1;
  assign in_ready  = (state == imuyz_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= imuyz_pkg::ST_IDLE;
      rot            <= imuyz_pkg::ROT_R45;
      cnt            <= '0;
      awaiting_first <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      rot            <= rot_next;
      cnt            <= cnt_next;
      awaiting_first <= awaiting_first_next;
      out_valid      <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next          = state;
    rot_next            = rot;
    cnt_next            = cnt;
    awaiting_first_next = awaiting_first;
    out_valid_next      = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      imuyz_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = imuyz_pkg::ST_ROT_LOAD;
          rot_next   = imuyz_pkg::ROT_R45;
        end
      end
      imuyz_pkg::ST_ROT_LOAD: begin
        cnt_next   = '0;
        state_next = (rot == imuyz_pkg::ROT_R45) ? imuyz_pkg::ST_QMUL : imuyz_pkg::ST_WRAP;
      end
      imuyz_pkg::ST_WRAP: state_next = imuyz_pkg::ST_FOLD;
      imuyz_pkg::ST_FOLD: begin
        cnt_next   = '0;
        state_next = imuyz_pkg::ST_CORDIC;
      end
      imuyz_pkg::ST_CORDIC: begin
        cnt_next = cnt + 5'd1;
        if (last_step) state_next = imuyz_pkg::ST_CS_DONE;
      end
      imuyz_pkg::ST_CS_DONE: begin
        cnt_next   = '0;
        state_next = imuyz_pkg::ST_QMUL;
      end
      imuyz_pkg::ST_QMUL: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd9) begin
          cnt_next = '0;
          unique case (rot)
            imuyz_pkg::ROT_MROLL: begin
              if (awaiting_first) begin
                state_next = imuyz_pkg::ST_YAW_MAC;
              end else begin
                state_next = imuyz_pkg::ST_ROT_LOAD;
                rot_next   = imuyz_pkg::ROT_SYAW;
              end
            end
            imuyz_pkg::ROT_SYAW: state_next = imuyz_pkg::ST_OUT;
            imuyz_pkg::ROT_R45: begin
              state_next = imuyz_pkg::ST_ROT_LOAD;
              rot_next   = imuyz_pkg::ROT_MYAW;
            end
            imuyz_pkg::ROT_MYAW: begin
              state_next = imuyz_pkg::ST_ROT_LOAD;
              rot_next   = imuyz_pkg::ROT_MPITCH;
            end
            default: begin
              state_next = imuyz_pkg::ST_ROT_LOAD;
              rot_next   = imuyz_pkg::ROT_MROLL;
            end
          endcase
        end
      end
      imuyz_pkg::ST_YAW_MAC: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd4) state_next = imuyz_pkg::ST_YAW_NORM;
      end
      imuyz_pkg::ST_YAW_NORM: begin
        cnt_next = '0;
        if (status.t_zero) state_next = imuyz_pkg::ST_YAW_LATCH;
        else if (!status.t_big) state_next = imuyz_pkg::ST_YAW_PRE;
      end
      imuyz_pkg::ST_YAW_PRE: begin
        cnt_next   = '0;
        state_next = imuyz_pkg::ST_YAW_CORDIC;
      end
      imuyz_pkg::ST_YAW_CORDIC: begin
        cnt_next = cnt + 5'd1;
        if (last_step) state_next = imuyz_pkg::ST_YAW_LATCH;
      end
      imuyz_pkg::ST_YAW_LATCH: begin
        awaiting_first_next = 1'b0;
        rot_next            = imuyz_pkg::ROT_SYAW;
        state_next          = imuyz_pkg::ST_ROT_LOAD;
      end
      imuyz_pkg::ST_OUT: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = imuyz_pkg::ST_IDLE;
        end
      end
      default: state_next = imuyz_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.rot  = rot;
    cmd.step = cnt;
    unique case (state)
      imuyz_pkg::ST_IDLE:     cmd.load_in = in_valid;
      imuyz_pkg::ST_ROT_LOAD: cmd.cs_load = 1'b1;
      imuyz_pkg::ST_WRAP:     cmd.cs_wrap = 1'b1;
      imuyz_pkg::ST_FOLD:     cmd.cs_fold = 1'b1;
      imuyz_pkg::ST_CORDIC:   cmd.cor_step = 1'b1;
      imuyz_pkg::ST_CS_DONE:  cmd.cs_done = 1'b1;
      imuyz_pkg::ST_QMUL: begin
        cmd.mac_en    = (cnt < 5'd8);
        cmd.mac_clr   = !cnt[0];
        cmd.mac_comp  = cnt[2:1];
        cmd.mac_term  = cnt[0];
        // write back a component once both of its terms are summed
        cmd.q_wr      = (cnt != 5'd0) && !cnt[0] && (cnt <= 5'd8);
        cmd.q_wr_comp = cnt_m1[2:1];
        cmd.q_commit  = (cnt == 5'd9);
      end
      imuyz_pkg::ST_YAW_MAC: begin
        cmd.mac_en   = (cnt < 5'd4);
        cmd.mac_yaw  = 1'b1;
        cmd.mac_clr  = !cnt[0];
        cmd.mac_comp = cnt[1:0];
        cmd.t0_wr    = (cnt == 5'd2);
        cmd.t1_wr    = (cnt == 5'd4);
      end
      imuyz_pkg::ST_YAW_NORM: cmd.t_shift = status.t_big && !status.t_zero;
      imuyz_pkg::ST_YAW_PRE:  cmd.yaw_pre = 1'b1;
      imuyz_pkg::ST_YAW_CORDIC: begin
        cmd.cor_step = 1'b1;
        cmd.cor_vec  = 1'b1;
      end
      imuyz_pkg::ST_YAW_LATCH: cmd.yaw_latch = 1'b1;
      imuyz_pkg::ST_OUT:       cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/imuyz_dpath.sv =====
// ----------------------------------------------------------------------------
// imuyz_dpath
// Shared multiply-accumulate, iterative CORDIC (rotation and vectoring),
// quaternion registers, yaw capture and saturating output register.
// ----------------------------------------------------------------------------
module imuyz_dpath (
  input  logic                clk,
  input  imuyz_pkg::cmd_t     cmd,
  output imuyz_pkg::status_t  status,
  input  logic signed [15:0]  in_w,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic signed [15:0]  in_z,
  input  logic signed [14:0]  mount_roll,
  input  logic signed [14:0]  mount_pitch,
  input  logic signed [14:0]  mount_yaw,
  output logic signed [15:0]  out_w,
  output logic signed [15:0]  out_x,
  output logic signed [15:0]  out_y,
  output logic signed [15:0]  out_z
);

  localparam int QW  = imuyz_pkg::QW;
  localparam int CSW = imuyz_pkg::CSW;
  localparam int PW  = imuyz_pkg::PW;
  localparam int AW  = imuyz_pkg::AW;
  localparam int TW  = imuyz_pkg::TW;
  localparam int CXW = imuyz_pkg::CXW;
  localparam int CZW = imuyz_pkg::CZW;

  logic signed [QW-1:0]  q  [4];
  logic signed [QW-1:0]  qn [4];
  logic signed [CSW-1:0] c_r, s_r;
  logic signed [AW-1:0]  acc;
  logic signed [TW-1:0]  tx, ty;
  logic signed [CXW-1:0] cx, cy;
  logic signed [CZW-1:0] cz;
  logic                  neg_r;
  logic signed [15:0]    start_yaw;

  // multiplier operands
  imuyz_pkg::term_t      pt;
  logic signed [QW-1:0]  ma, mb;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  addend, acc_base;
  logic signed [AW-1:0]  acc_rnd;
  logic                  mneg;

  always_comb begin
    pt   = imuyz_pkg::partner(cmd.rot, cmd.mac_comp);
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    if (cmd.mac_yaw) begin
      // y*y, z*z, then x*y, w*z
      case (cmd.mac_comp)
        2'd0:    begin ma = q[imuyz_pkg::IDX_Y]; mb = q[imuyz_pkg::IDX_Y]; end
        2'd1:    begin ma = q[imuyz_pkg::IDX_Z]; mb = q[imuyz_pkg::IDX_Z]; end
        2'd2:    begin ma = q[imuyz_pkg::IDX_X]; mb = q[imuyz_pkg::IDX_Y]; end
        default: begin ma = q[imuyz_pkg::IDX_W]; mb = q[imuyz_pkg::IDX_Z]; end
      endcase
    end else if (cmd.mac_term) begin
      ma   = QW'(s_r);
      mb   = q[pt.idx];
      mneg = pt.neg;
    end else begin
      ma = QW'(c_r);
      mb = q[cmd.mac_comp];
    end
  end

  assign prod     = ma * mb;
  assign addend   = mneg ? -AW'(prod) : AW'(prod);
  assign acc_base = cmd.mac_clr ? '0 : acc;
  assign acc_rnd  = (acc + (AW'(1) <<< (imuyz_pkg::QUAT_FRAC_BITS - 1)))
                    >>> imuyz_pkg::QUAT_FRAC_BITS;

  // CORDIC step
  logic signed [CXW-1:0] dx, dy;
  logic signed [CZW-1:0] at;
  logic                  up;
  assign dx = cy >>> cmd.step;
  assign dy = cx >>> cmd.step;
  assign at = imuyz_pkg::atan_step(cmd.step);
  assign up = cmd.cor_vec ? (cy < 0) : (cz >= 0);

  // angle source for sin / cos
  logic signed [imuyz_pkg::ANGW-1:0] ang;
  always_comb begin
    case (cmd.rot)
      imuyz_pkg::ROT_MYAW:   ang = imuyz_pkg::ANGW'(mount_yaw);
      imuyz_pkg::ROT_MPITCH: ang = imuyz_pkg::ANGW'(mount_pitch);
      imuyz_pkg::ROT_MROLL:  ang = imuyz_pkg::ANGW'(mount_roll);
      imuyz_pkg::ROT_SYAW:   ang = -imuyz_pkg::ANGW'(start_yaw);
      default:               ang = '0;
    endcase
  end

  logic signed [CXW-1:0] xs, ys, xr, yr;
  assign xs = neg_r ? -cx : cx;
  assign ys = neg_r ? -cy : cy;
  assign xr = (xs + (CXW'(1) <<< (imuyz_pkg::RND_CS - 1))) >>> imuyz_pkg::RND_CS;
  assign yr = (ys + (CXW'(1) <<< (imuyz_pkg::RND_CS - 1))) >>> imuyz_pkg::RND_CS;

  logic signed [CZW-1:0] yaw_rnd;
  assign yaw_rnd = (cz + (CZW'(1) <<< (imuyz_pkg::RND_ANG - 1))) >>> imuyz_pkg::RND_ANG;

  assign status.t_big  = (tx >= imuyz_pkg::T_LIM) || (tx <= -imuyz_pkg::T_LIM) ||
                         (ty >= imuyz_pkg::T_LIM) || (ty <= -imuyz_pkg::T_LIM);
  assign status.t_zero = (tx == '0) && (ty == '0);

  function automatic logic signed [15:0] sat_out(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = v;
    if (v > imuyz_pkg::OUT_LIM) r = imuyz_pkg::OUT_LIM;
    if (v < -imuyz_pkg::OUT_LIM) r = -imuyz_pkg::OUT_LIM;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      q[imuyz_pkg::IDX_W] <= QW'(in_w);
      q[imuyz_pkg::IDX_X] <= QW'(in_x);
      q[imuyz_pkg::IDX_Y] <= QW'(in_y);
      q[imuyz_pkg::IDX_Z] <= QW'(in_z);
    end else if (cmd.q_commit) begin
      q <= qn;
    end

    if (cmd.mac_en) acc <= acc_base + addend;
    if (cmd.q_wr) qn[cmd.q_wr_comp] <= acc_rnd[QW-1:0];
    if (cmd.t0_wr) begin
      tx <= TW'((AW'(1) <<< (2 * imuyz_pkg::QUAT_FRAC_BITS)) - (acc <<< 1));
    end
    if (cmd.t1_wr) ty <= TW'(acc <<< 1);
    if (cmd.t_shift) begin
      tx <= tx >>> 1;
      ty <= ty >>> 1;
    end

    if (cmd.cs_load) begin
      if (cmd.rot == imuyz_pkg::ROT_R45) begin
        c_r <= imuyz_pkg::R45_C;
        s_r <= -imuyz_pkg::R45_C;
      end
      cx    <= imuyz_pkg::GAIN_Q30;
      cy    <= '0;
      cz    <= CZW'(ang) <<< imuyz_pkg::HALF_SHIFT;
      neg_r <= 1'b0;
    end
    if (cmd.cs_wrap) begin
      if (cz > imuyz_pkg::PI_Q30) cz <= cz - imuyz_pkg::TWO_PI_Q30;
      else if (cz < -imuyz_pkg::PI_Q30) cz <= cz + imuyz_pkg::TWO_PI_Q30;
    end
    if (cmd.cs_fold) begin
      if (cz > imuyz_pkg::HALF_PI_Q30) begin
        cz    <= cz - imuyz_pkg::PI_Q30;
        neg_r <= 1'b1;
      end else if (cz < -imuyz_pkg::HALF_PI_Q30) begin
        cz    <= cz + imuyz_pkg::PI_Q30;
        neg_r <= 1'b1;
      end
    end
    if (cmd.yaw_pre) begin
      // pre-rotate by pi when the vector points into the left half plane
      if (tx < 0) begin
        cx <= CXW'(-tx);
        cy <= CXW'(-ty);
        cz <= (ty >= 0) ? imuyz_pkg::PI_Q30 : -imuyz_pkg::PI_Q30;
      end else begin
        cx <= CXW'(tx);
        cy <= CXW'(ty);
        cz <= '0;
      end
    end
    if (cmd.cor_step) begin
      if (up) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
    if (cmd.cs_done) begin
      c_r <= xr[CSW-1:0];
      s_r <= yr[CSW-1:0];
    end
    if (cmd.yaw_latch) begin
      if (status.t_zero) start_yaw <= '0;
      else if (yaw_rnd > CZW'(32767)) start_yaw <= 16'sh7fff;
      else if (yaw_rnd < -CZW'(32768)) start_yaw <= 16'sh8000;
      else start_yaw <= yaw_rnd[15:0];
    end
    if (cmd.out_load) begin
      out_w <= sat_out(q[imuyz_pkg::IDX_W]);
      out_x <= sat_out(q[imuyz_pkg::IDX_X]);
      out_y <= sat_out(q[imuyz_pkg::IDX_Y]);
      out_z <= sat_out(q[imuyz_pkg::IDX_Z]);
    end
  end

endmodule

// ===== tb/sv/tb_imu_quaternion_mount_and_yaw_zero.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_quaternion_mount_and_yaw_zero
// Self-checking bench: quaternions go in over valid/ready, mounting angles
// over APB between phases; a bit-exact fixed-point predictor checks every
// corrected quaternion in order, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_imu_quaternion_mount_and_yaw_zero;

  typedef longint quat_t [0:3];
  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } sample_t;

  localparam longint PI30 = 64'sd3373259426;
  localparam longint HPI30 = 64'sd1686629713;
  localparam longint TPI30 = 64'sd6746518852;
  localparam longint K30 = 64'sd652032874;
  localparam longint R45 = 64'sd759250125;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic in_ready, out_valid, pready;
  logic signed [15:0] in_w = '0, in_x = '0, in_y = '0, in_z = '0;
  logic signed [15:0] out_w, out_x, out_y, out_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [imuyz_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  sample_t samples_to_send[$];
  sample_t pending_quats[$];
  longint mnt_roll = 0, mnt_pitch = 0, mnt_yaw = 0, zero_yaw = 0;
  bit first_pending = 1'b1;
  bit in_took = 1'b0;
  int idle_in_pct = 0, idle_out_pct = 0;
  int errors = 0, quiet_cycles = 0;

  imu_quaternion_mount_and_yaw_zero dut (.*);

  always #5 clk = ~clk;

  function automatic longint elem_angle(int i);
    longint tab [0:9] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return tab[i];
    return 64'sd1 <<< (30 - i);
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // half-angle rotation coefficients, angle h in Q.30
  function automatic void cos_sin(longint h, output longint c, output longint s);
    longint r, x, y, dx, dy;
    bit flip;
    r = h % TPI30;
    x = K30;
    y = 0;
    flip = 1'b0;
    if (r > PI30) r -= TPI30;
    else if (r < -PI30) r += TPI30;
    if (r > HPI30) begin
      r -= PI30; flip = 1'b1;
    end else if (r < -HPI30) begin
      r += PI30; flip = 1'b1;
    end
    for (int i = 0; i < imuyz_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= elem_angle(i);
      end else begin
        x += dx; y -= dy; r += elem_angle(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = round_sh(x, 30 - imuyz_pkg::QUAT_FRAC_BITS);
    s = round_sh(y, 30 - imuyz_pkg::QUAT_FRAC_BITS);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (x >= (64'sd1 <<< 30) || x <= -(64'sd1 <<< 30) ||
           y >= (64'sd1 <<< 30) || y <= -(64'sd1 <<< 30)) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    if (x < 0) begin
      z = (y >= 0) ? PI30 : -PI30;
      x = -x; y = -y;
    end
    for (int i = 0; i < imuyz_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += elem_angle(i);
      end else begin
        x -= dx; y += dy; z -= elem_angle(i);
      end
    end
    return z;
  endfunction

  function automatic quat_t hamilton(quat_t a, quat_t b);
    quat_t r;
    r[0] = round_sh(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3],
                    imuyz_pkg::QUAT_FRAC_BITS);
    r[1] = round_sh(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2],
                    imuyz_pkg::QUAT_FRAC_BITS);
    r[2] = round_sh(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1],
                    imuyz_pkg::QUAT_FRAC_BITS);
    r[3] = round_sh(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0],
                    imuyz_pkg::QUAT_FRAC_BITS);
    return r;
  endfunction

  function automatic longint half_angle(longint a);
    return a * (64'sd1 <<< (29 - imuyz_pkg::ANGLE_FRAC_BITS));
  endfunction

  // expected corrected quaternion; latches the zero yaw on the first sample
  function automatic sample_t correct_quat(sample_t smp);
    quat_t q, rot;
    longint c, s, t0, t1, a, v, lim;
    sample_t res;
    q = '{smp.w, smp.x, smp.y, smp.z};
    c = round_sh(R45, 30 - imuyz_pkg::QUAT_FRAC_BITS);
    q = hamilton(q, '{c, 0, 0, -c});
    cos_sin(half_angle(mnt_yaw), c, s);
    q = hamilton(q, '{c, 0, 0, s});
    cos_sin(half_angle(mnt_pitch), c, s);
    q = hamilton(q, '{c, 0, s, 0});
    cos_sin(half_angle(mnt_roll), c, s);
    q = hamilton(q, '{c, s, 0, 0});
    if (first_pending) begin
      t0 = (64'sd1 <<< (2 * imuyz_pkg::QUAT_FRAC_BITS)) - 2 * (q[2]*q[2] + q[3]*q[3]);
      t1 = 2 * (q[1]*q[2] + q[0]*q[3]);
      a = round_sh(vector_angle(t1, t0), 30 - imuyz_pkg::ANGLE_FRAC_BITS);
      if (a > 32767) a = 32767;
      if (a < -32768) a = -32768;
      zero_yaw = a;
      first_pending = 1'b0;
    end
    cos_sin(-half_angle(zero_yaw), c, s);
    rot = '{c, 0, 0, s};
    q = hamilton(rot, q);
    lim = 64'sd1 <<< imuyz_pkg::QUAT_FRAC_BITS;
    for (int i = 0; i < 4; i++) begin
      v = q[i];
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      q[i] = v;
    end
    res.w = q[0][15:0];
    res.x = q[1][15:0];
    res.y = q[2][15:0];
    res.z = q[3][15:0];
    return res;
  endfunction

  task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_sample(sample_t smp);
    samples_to_send = {samples_to_send, smp};
  endtask

  // driver: hold the payload until the transaction is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (samples_to_send.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          sample_t smp;
          smp = samples_to_send.pop_front();
          in_valid <= 1'b1;
          in_w <= smp.w;
          in_x <= smp.x;
          in_y <= smp.y;
          in_z <= smp.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    sample_t want;
    sample_t pred;
    in_took <= in_valid && in_ready && !rst;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready) begin
        pred = correct_quat('{in_w, in_x, in_y, in_z});
        pending_quats = {pending_quats, pred};
      end
      if (out_valid && out_ready) begin
        if (pending_quats.size() == 0) begin
          report("out_w (no transaction expected)", out_w, 16'sd0);
        end else begin
          want = pending_quats.pop_front();
          if (out_w !== want.w) report("out_w", out_w, want.w);
          if (out_x !== want.x) report("out_x", out_x, want.x);
          if (out_y !== want.y) report("out_y", out_y, want.y);
          if (out_z !== want.z) report("out_z", out_z, want.z);
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("imu_quaternion_mount_and_yaw_zero regression: fail");
        $finish;
      end
    end
  end

  task automatic apb_write(int idx, longint val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= imuyz_pkg::PADDR_W'(4 * idx);
    pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      imuyz_pkg::REG_ROLL:  mnt_roll = val;
      imuyz_pkg::REG_PITCH: mnt_pitch = val;
      imuyz_pkg::REG_YAW:   mnt_yaw = val;
      default: ;
    endcase
  endtask

  task automatic set_mount(longint r, longint p, longint y);
    apb_write(imuyz_pkg::REG_ROLL, r);
    apb_write(imuyz_pkg::REG_PITCH, p);
    apb_write(imuyz_pkg::REG_YAW, y);
  endtask

  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    return 16'($urandom_range(32768)) - 16'sd16384;
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      add_sample('{rand_comp(), rand_comp(), rand_comp(), rand_comp()});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (samples_to_send.size() > 0 || in_valid || pending_quats.size() > 0);
  endtask

  function automatic longint rand_angle();
    return longint'($urandom_range(32767)) - 16384;
  endfunction

  initial begin
    idle_in_pct = 33;
    idle_out_pct = 85;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: first sample fixes the zero yaw, then extremes
    set_mount(0, 0, 0);
    add_sample('{16'sd12000, 16'sd3000, -16'sd5000, 16'sd9000});
    add_sample('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    add_sample('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    add_sample('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    add_sample('{16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    add_sample('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    add_sample('{16'sd0, 16'sd0, -16'sd16384, 16'sd0});
    add_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    add_sample('{16'sd0, 16'sd0, 16'sd0, -16'sd16384});
    add_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    // non-unit inputs drive the output into saturation, then a unit input
    add_sample('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    add_sample('{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
    add_sample('{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384});
    add_sample('{16'sd11585, 16'sd0, 16'sd0, 16'sd11585});
    drain();

    // angle extremes, out-of-range values and an unmapped register
    set_mount(12868, 12868, 12868);
    apb_write(3, 16'h1234);
    queue_random(10);
    drain();
    set_mount(-12868, -12868, -12868);
    queue_random(230);
    drain();
    set_mount(16383, -16384, 16383);
    queue_random(230);
    drain();

    idle_in_pct = 85;
    idle_out_pct = 33;
    set_mount(rand_angle(), rand_angle(), rand_angle());
    queue_random(230);
    drain();
    set_mount(-16384, 16383, -16384);
    queue_random(230);
    drain();

    idle_in_pct = 0;
    idle_out_pct = 0;
    set_mount(rand_angle(), rand_angle(), rand_angle());
    queue_random(230);
    drain();
    set_mount(0, 0, 0);
    queue_random(230);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("imu_quaternion_mount_and_yaw_zero regression: pass");
    else
      $display("imu_quaternion_mount_and_yaw_zero regression: fail");
    $finish;
  end

endmodule
